// ===== design/scan_breakpoint_clustering_top_defines.svh =====
// Assertion macros used by the top-level file to check this block.
`ifndef SCAN_BREAKPOINT_CLUSTERING_TOP_DEFINES_SVH
`define SCAN_BREAKPOINT_CLUSTERING_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sbc_pkg.sv =====
package sbc_pkg;

    localparam int MAX_BEAMS = 1024;
    localparam int BEAM_W = $clog2(MAX_BEAMS);
    localparam int LEN_W = BEAM_W + 1;
    localparam int OUT_BEAM_W = 10;
    localparam int CNT_W = 10;
    localparam int COORD_W = 16;
    localparam int POINT_W = 2 * COORD_W;
    localparam int ROOT_W = 17;
    localparam int SQ_W = 2 * ROOT_W;
    localparam int GAP_W = 15;
    localparam int GAP_SQ_W = 2 * GAP_W;
    localparam int PCT_W = 7;
    localparam int CMP_W = LEN_W + 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_BREAK_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DYN_PCT = 2'd1;

    localparam logic [GAP_W-1:0] GAP_RESET = 15'd200;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd75;
    localparam logic [7:0] PERCENT_SCALE = 8'd100;

    typedef struct packed {
        logic accept;
        logic mul_step;
        logic skip_step;
        logic update;
        logic load_brk;
        logic load_close;
        logic advance;
        logic emit_mul;
        logic sqrt_start;
        logic mid_cap;
        logic out_load;
        logic end_scan;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic beam_zero;
        logic brk;
        logic closing;
        logic sqrt_done;
        logic out_free;
        logic job_item_last;
        logic job_scan_last;
    } t_dp_sts;

endpackage

// ===== design/sbc_ram.sv =====
module sbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sbc_isqrt.sv =====
module sbc_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sbc_pkg::SQ_W-1:0]  i_rad,
    output logic                      o_busy,
    output logic [sbc_pkg::ROOT_W-1:0] o_root
);

    localparam int ITER_W = $clog2(sbc_pkg::ROOT_W + 1);
    localparam int REM_W = sbc_pkg::ROOT_W + 3;

    logic                       r_busy;
    logic [ITER_W-1:0]          r_iter;
    logic [sbc_pkg::SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]           r_rem;
    logic [sbc_pkg::ROOT_W-1:0] r_root;
    logic [REM_W-1:0]           n_rem_t;
    logic [REM_W-1:0]           n_trial;
    logic                       n_ge;

    always_comb begin
        n_rem_t = {r_rem[REM_W-3:0], r_rad[sbc_pkg::SQ_W-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
        n_ge = n_rem_t >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_iter <= ITER_W'(sbc_pkg::ROOT_W);
        end else if (r_busy) begin
            r_iter <= r_iter - 1'b1;
            if (r_iter == ITER_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad <= i_rad;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[sbc_pkg::SQ_W-3:0], 2'b00};
            r_rem <= n_ge ? (n_rem_t - n_trial) : n_rem_t;
            r_root <= {r_root[sbc_pkg::ROOT_W-2:0], n_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== design/sbc_ctrl.sv =====
module sbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  sbc_pkg::t_dp_sts i_sts,
    output sbc_pkg::t_dp_cmd o_cmd,
    output logic             o_in_stall
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_MUL    = 8'b00000010,
        S_TEST   = 8'b00000100,
        S_CLOSE  = 8'b00001000,
        S_E_MUL  = 8'b00010000,
        S_E_SQ   = 8'b00100000,
        S_E_WAIT = 8'b01000000,
        S_E_OUT  = 8'b10000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_sts.skip) begin
                    o_cmd.skip_step = 1'b1;
                    n_state = S_IDLE;
                end else if (!i_sts.beam_zero && i_sts.brk) begin
                    o_cmd.load_brk = 1'b1;
                    n_state = S_E_MUL;
                end else begin
                    o_cmd.update = 1'b1;
                    if (i_sts.closing) begin
                        n_state = S_CLOSE;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end
            S_CLOSE: begin
                o_cmd.load_close = 1'b1;
                n_state = S_E_MUL;
            end
            S_E_MUL: begin
                o_cmd.emit_mul = 1'b1;
                n_state = S_E_SQ;
            end
            S_E_SQ: begin
                o_cmd.sqrt_start = 1'b1;
                o_cmd.mid_cap = 1'b1;
                n_state = S_E_WAIT;
            end
            S_E_WAIT: begin
                if (i_sts.sqrt_done) begin
                    n_state = S_E_OUT;
                end
            end
            S_E_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.job_scan_last) begin
                        o_cmd.end_scan = 1'b1;
                        n_state = S_IDLE;
                    end else if (i_sts.job_item_last) begin
                        o_cmd.advance = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_CLOSE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

// ===== design/sbc_datapath.sv =====
module sbc_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbc_pkg::t_dp_cmd                  i_cmd,
    output sbc_pkg::t_dp_sts                  o_sts,
    input  logic                              i_cfg_valid,
    input  logic [sbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sbc_pkg::GAP_W-1:0]         i_cfg_data,
    input  logic signed [sbc_pkg::COORD_W-1:0] i_x_mm,
    input  logic signed [sbc_pkg::COORD_W-1:0] i_y_mm,
    input  logic                              i_moving,
    input  logic                              i_end_of_scan,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [sbc_pkg::CNT_W-1:0]         o_cluster_number,
    output logic [sbc_pkg::OUT_BEAM_W-1:0]    o_first_beam,
    output logic [sbc_pkg::OUT_BEAM_W-1:0]    o_final_beam,
    output logic [sbc_pkg::ROOT_W-1:0]        o_width_mm,
    output logic signed [sbc_pkg::COORD_W-1:0] o_middle_x,
    output logic signed [sbc_pkg::COORD_W-1:0] o_middle_y,
    output logic                              o_is_dynamic,
    output logic                              o_last_of_item,
    output logic                              o_last_of_scan
);

    localparam int CW = sbc_pkg::COORD_W;
    localparam int BW = sbc_pkg::BEAM_W;
    localparam int LW = sbc_pkg::LEN_W;

    logic [sbc_pkg::GAP_W-1:0]    r_gap;
    logic [sbc_pkg::PCT_W-1:0]    r_pct;
    logic [sbc_pkg::GAP_SQ_W-1:0] r_gap_sq;

    logic [CW-1:0] r_x, r_y;
    logic          r_mv, r_eos;
    logic [BW-1:0] r_beam, r_start;
    logic [sbc_pkg::CNT_W-1:0] r_count;
    logic [LW-1:0] r_mcount;
    logic [CW-1:0] r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic          r_skip;

    logic [BW-1:0] r_job_first, r_job_last;
    logic [LW-1:0] r_job_m;
    logic [CW-1:0] r_job_fx, r_job_fy, r_job_lx, r_job_ly;
    logic          r_job_il, r_job_sl;

    logic [sbc_pkg::SQ_W-1:0]  r_dx2, r_dy2;
    logic [sbc_pkg::CMP_W-1:0] r_pm, r_pl;
    logic [CW-1:0]             r_mid_x, r_mid_y;

    logic                        r_out_valid;
    logic [sbc_pkg::CNT_W-1:0]   r_o_num;
    logic [BW-1:0]               r_o_first, r_o_last;
    logic [sbc_pkg::ROOT_W-1:0]  r_o_width;
    logic [CW-1:0]               r_o_mx, r_o_my;
    logic                        r_o_dyn, r_o_il, r_o_sl;

    logic [CW-1:0]            n_ax, n_ay, n_bx, n_by;
    logic signed [CW:0]       n_dx, n_dy;
    logic signed [sbc_pkg::SQ_W-1:0] n_dx2, n_dy2;
    logic [sbc_pkg::SQ_W:0]   n_dsum;
    logic [sbc_pkg::SQ_W:0]   n_esum;
    logic [LW-1:0]            n_len;
    logic [LW-1:0]            n_mid_sum;
    logic [sbc_pkg::POINT_W-1:0] n_rdata;
    logic                     n_sqrt_busy;
    logic [sbc_pkg::ROOT_W-1:0] n_root;
    logic                     n_out_free;

    always_comb begin
        if (i_cmd.emit_mul) begin
            n_ax = r_job_fx;
            n_ay = r_job_fy;
            n_bx = r_job_lx;
            n_by = r_job_ly;
        end else begin
            n_ax = r_x;
            n_ay = r_y;
            n_bx = r_prev_x;
            n_by = r_prev_y;
        end
        n_dx = $signed({n_ax[CW-1], n_ax}) - $signed({n_bx[CW-1], n_bx});
        n_dy = $signed({n_ay[CW-1], n_ay}) - $signed({n_by[CW-1], n_by});
        n_dx2 = sbc_pkg::SQ_W'(n_dx) * sbc_pkg::SQ_W'(n_dx);
        n_dy2 = sbc_pkg::SQ_W'(n_dy) * sbc_pkg::SQ_W'(n_dy);
        n_dsum = {1'b0, r_dx2} + {1'b0, r_dy2};
        n_esum = n_dsum;
        n_len = {1'b0, r_job_last} - {1'b0, r_job_first} + LW'(1);
        n_mid_sum = ({1'b0, r_job_first} + {1'b0, r_job_last}) >> 1;
        n_out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        o_sts.skip = r_skip;
        o_sts.beam_zero = r_beam == '0;
        o_sts.brk = n_dsum > (sbc_pkg::SQ_W + 1)'(r_gap_sq);
        o_sts.closing = r_eos || (r_beam == BW'(sbc_pkg::MAX_BEAMS - 1));
        o_sts.sqrt_done = !n_sqrt_busy;
        o_sts.out_free = n_out_free;
        o_sts.job_item_last = r_job_il;
        o_sts.job_scan_last = r_job_sl;
    end

    sbc_ram #(
        .WIDTH (sbc_pkg::POINT_W),
        .DEPTH (sbc_pkg::MAX_BEAMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && !r_skip),
        .i_waddr (r_beam),
        .i_wdata ({i_y_mm, i_x_mm}),
        .i_re    (i_cmd.emit_mul),
        .i_raddr (n_mid_sum[BW-1:0]),
        .o_rdata (n_rdata)
    );

    sbc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_rad   (n_esum[sbc_pkg::SQ_W-1:0]),
        .o_busy  (n_sqrt_busy),
        .o_root  (n_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= sbc_pkg::GAP_RESET;
            r_pct <= sbc_pkg::PCT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sbc_pkg::CFG_BREAK_GAP: r_gap <= i_cfg_data;
                sbc_pkg::CFG_DYN_PCT:   r_pct <= i_cfg_data[sbc_pkg::PCT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap_sq <= r_gap * r_gap;
        if (i_cmd.accept) begin
            r_x <= i_x_mm;
            r_y <= i_y_mm;
            r_mv <= i_moving;
            r_eos <= i_end_of_scan;
        end
        if (i_cmd.mul_step || i_cmd.emit_mul) begin
            r_dx2 <= $unsigned(n_dx2);
            r_dy2 <= $unsigned(n_dy2);
        end
        if (i_cmd.emit_mul) begin
            r_pm <= sbc_pkg::CMP_W'(r_job_m) * sbc_pkg::CMP_W'(sbc_pkg::PERCENT_SCALE);
            r_pl <= sbc_pkg::CMP_W'({1'b0, r_pct} + 8'd1) * sbc_pkg::CMP_W'(n_len);
        end
        if (i_cmd.mid_cap) begin
            r_mid_x <= n_rdata[CW-1:0];
            r_mid_y <= n_rdata[sbc_pkg::POINT_W-1:CW];
        end
        if (i_cmd.load_brk) begin
            r_job_first <= r_start;
            r_job_last <= r_beam - 1'b1;
            r_job_m <= r_mcount;
            r_job_fx <= r_first_x;
            r_job_fy <= r_first_y;
            r_job_lx <= r_prev_x;
            r_job_ly <= r_prev_y;
            r_job_il <= !o_sts.closing;
            r_job_sl <= 1'b0;
        end else if (i_cmd.load_close) begin
            r_job_first <= r_start;
            r_job_last <= r_beam;
            r_job_m <= r_mcount;
            r_job_fx <= r_first_x;
            r_job_fy <= r_first_y;
            r_job_lx <= r_prev_x;
            r_job_ly <= r_prev_y;
            r_job_il <= 1'b1;
            r_job_sl <= 1'b1;
        end
        if (i_cmd.load_brk || (i_cmd.update && r_beam == '0)) begin
            r_first_x <= r_x;
            r_first_y <= r_y;
        end
        if (i_cmd.out_load) begin
            r_o_num <= r_count;
            r_o_first <= r_job_first;
            r_o_last <= r_job_last;
            r_o_width <= n_root;
            r_o_mx <= r_mid_x;
            r_o_my <= r_mid_y;
            r_o_dyn <= r_pm >= r_pl;
            r_o_il <= r_job_il;
            r_o_sl <= r_job_sl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam <= '0;
            r_start <= '0;
            r_count <= '0;
            r_mcount <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_skip <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.skip_step && r_eos) begin
                r_skip <= 1'b0;
                r_beam <= '0;
                r_start <= '0;
                r_count <= '0;
                r_mcount <= '0;
            end
            if (i_cmd.update) begin
                r_prev_x <= r_x;
                r_prev_y <= r_y;
                if (r_beam == '0) begin
                    r_start <= '0;
                    r_mcount <= LW'(r_mv);
                end else begin
                    r_mcount <= r_mcount + LW'(r_mv);
                end
            end
            if (i_cmd.load_brk) begin
                r_prev_x <= r_x;
                r_prev_y <= r_y;
                r_start <= r_beam;
                r_mcount <= LW'(r_mv);
            end
            if (i_cmd.advance) begin
                r_beam <= r_beam + 1'b1;
            end
            if (i_cmd.end_scan) begin
                r_beam <= '0;
                r_start <= '0;
                r_count <= '0;
                r_mcount <= '0;
                r_skip <= !r_eos;
            end else if (i_cmd.out_load) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cluster_number = r_o_num;
    assign o_first_beam = sbc_pkg::OUT_BEAM_W'(r_o_first);
    assign o_final_beam = sbc_pkg::OUT_BEAM_W'(r_o_last);
    assign o_width_mm = r_o_width;
    assign o_middle_x = r_o_mx;
    assign o_middle_y = r_o_my;
    assign o_is_dynamic = r_o_dyn;
    assign o_last_of_item = r_o_il;
    assign o_last_of_scan = r_o_sl;

endmodule

// ===== design/scan_breakpoint_clustering_top.sv =====
// Breakpoint clustering of a laser scan, one beam per input transaction. Points are kept in a
// 1024-entry store; a cluster is closed when the gap to the previous point exceeds the break gap,
// at the end of the scan or at the last beam of the store, and one output transaction is produced
// per closed cluster (two when a break coincides with the end of the scan or of the store).
// Each closed cluster waits for the 17-step iterative square root of the cluster width, plus any
// time the output stays stalled. Configuration is to be written through the configuration port
// only while the block is idle; the block itself does not enforce this. Index 0 is the break gap
// and index 1 the dynamic percentage. The point store needs no initialization after reset.
`include "scan_breakpoint_clustering_top_defines.svh"

module scan_breakpoint_clustering_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbc_pkg::GAP_W-1:0]          i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [sbc_pkg::COORD_W-1:0] i_x_mm,
    input  logic signed [sbc_pkg::COORD_W-1:0] i_y_mm,
    input  logic                               i_moving,
    input  logic                               i_end_of_scan,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [sbc_pkg::CNT_W-1:0]          o_cluster_number,
    output logic [sbc_pkg::OUT_BEAM_W-1:0]     o_first_beam,
    output logic [sbc_pkg::OUT_BEAM_W-1:0]     o_final_beam,
    output logic [sbc_pkg::ROOT_W-1:0]         o_width_mm,
    output logic signed [sbc_pkg::COORD_W-1:0] o_middle_x,
    output logic signed [sbc_pkg::COORD_W-1:0] o_middle_y,
    output logic                               o_is_dynamic,
    output logic                               o_last_of_item,
    output logic                               o_last_of_scan
);

    sbc_pkg::t_dp_cmd n_cmd;
    sbc_pkg::t_dp_sts n_sts;

    assign o_cfg_ready = 1'b1;

    sbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (n_sts),
        .o_cmd      (n_cmd),
        .o_in_stall (o_in_stall)
    );

    sbc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (n_cmd),
        .o_sts            (n_sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_x_mm           (i_x_mm),
        .i_y_mm           (i_y_mm),
        .i_moving         (i_moving),
        .i_end_of_scan    (i_end_of_scan),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_cluster_number (o_cluster_number),
        .o_first_beam     (o_first_beam),
        .o_final_beam     (o_final_beam),
        .o_width_mm       (o_width_mm),
        .o_middle_x       (o_middle_x),
        .o_middle_y       (o_middle_y),
        .o_is_dynamic     (o_is_dynamic),
        .o_last_of_item   (o_last_of_item),
        .o_last_of_scan   (o_last_of_scan)
    );

    `SBC_ASSERT_NEXT(a_stall_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input not stalled after a transaction")
    `SBC_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, n_cmd.out_load, o_out_valid, "result load did not raise valid")
    `SBC_ASSERT_SAME(a_scan_last_is_item_last, i_clk, i_rst_n, o_out_valid && o_last_of_scan, o_last_of_item, "scan end without item end")
    `SBC_ASSERT_SAME(a_load_only_when_free, i_clk, i_rst_n, n_cmd.out_load, n_sts.out_free, "result overwritten while stalled")

endmodule
